FILE: rtl/core/lors_pkg.sv
// Shared types and codes for the line occlusion range splitter.
`timescale 1ns / 1ps

package lors_pkg;

  localparam int unsigned MaxWidth = 4096;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_OCCLUDE = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_DUMP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_WIDTH = 2'd0,
    CFG_WINDOW_HEIGHT = 2'd1,
    CFG_SCROLLBAR_LEFT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST1,
    S_ST2,
    S_G1,
    S_G2,
    S_ORD,
    S_OEV,
    S_SRD,
    S_SWR,
    S_W1,
    S_W0,
    S_QRD,
    S_QEV,
    S_DRD,
    S_DEV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]         scrollbar_width;
    logic               scrollbar_reserved;
    logic               pane_visible;
    logic               pane_borderless;
    logic               pane_floating;
    logic [12:0]        pane_h;
    logic [12:0]        span_w;
    logic signed [13:0] y_pos;
    logic signed [13:0] x_pos;
  } item_t;

  // One stored range; start may reach 4096 only on a deleted range.
  typedef struct packed {
    logic [12:0] len;
    logic [12:0] x;
  } entry_t;

  // Covered column span of one occluding pane on the current row.
  typedef struct packed {
    logic        hit;
    logic [12:0] lb;
    logic [12:0] rb;
  } span_t;

endpackage

FILE: rtl/core/line_occlusion_range_splitter.sv
// Top level: visible column range store for one screen row.
`timescale 1ns / 1ps
//
// Input channel s_*: one transfer per request, kind in s_tuser (start row,
// occluding pane, query column, dump ranges). Output channel m_*: result
// transfers; a query gives one, a dump one per stored range (or a single
// empty one), m_tlast on the final result. Start and occluder give none.
// Configuration: cfg_we/cfg_index/cfg_wdata, written by the user only
// while the block idles; the block itself does not enforce it.
// Ranges live in a one-read/one-write RAM of MAX_RANGES entries with a
// registered read. A start clips its span, then writes it. The other
// requests step through the entries with a RAM read, then an evaluate,
// per entry: an occluder, once its span is ready, shifts later entries up
// and writes both halves on a split; a query stops at its hit.
// One request is worked at a time; s_tready is high only between requests.
// A finished result sits in the output register, so the next request is
// taken while it waits. A stalled receiver holds the walk of a dump at
// the next result. Reset (rst, synchronous) empties the store, clears the
// overflow flag and restores the window registers to 80 x 24; no
// clearing pass is needed.

module line_occlusion_range_splitter #(
  parameter int MAX_RANGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [13:0] x_pos, [27:14] y_pos, [40:28] span_w, [53:41] pane_h,
  // [54] pane_floating, [55] pane_borderless, [56] pane_visible,
  // [57] scrollbar_reserved, [65:58] scrollbar_width, rest zero
  input  logic [71:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [11:0] range_x, [24:12] range_len, [25] col_visible, [26] overflow
  output logic [31:0] m_tdata,
  // [0] range_valid
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES) + 2;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RANGES);

  // configuration
  logic [12:0] window_width, window_height;
  logic        sb_left;
  logic [12:0] ww;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= 13'd80;
      window_height <= 13'd24;
      sb_left       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lors_pkg::CFG_WINDOW_WIDTH:   window_width  <= cfg_wdata;
        lors_pkg::CFG_WINDOW_HEIGHT:  window_height <= cfg_wdata;
        lors_pkg::CFG_SCROLLBAR_LEFT: sb_left       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign ww = (window_width > 13'(lors_pkg::MaxWidth)) ? 13'(lors_pkg::MaxWidth)
                                                         : window_width;

  // state
  lors_pkg::state_t state, state_next;
  lors_pkg::item_t  item;
  logic [CW-1:0]    count, idx, sidx;
  logic [12:0]      row;
  logic             ovf, vis;
  logic             accept, slot_free;

  // start row staging
  logic        st_empty;
  logic [12:0] st_x, st_w;

  // saved entry for a split
  logic [12:0] sp_x;
  logic [14:0] sp_ex;

  // RAM
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  lors_pkg::entry_t      ram_wdata, rd;
  lors_pkg::span_t       span;

  lors_ram #(
    .WIDTH ($bits(lors_pkg::entry_t)),
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  lors_span u_span (
    .clk     (clk),
    .item    (item),
    .row     (row),
    .ww      (ww),
    .sb_left (sb_left),
    .span    (span)
  );

  assign s_tready  = (state == lors_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // entry evaluation against the pane span
  logic [14:0] sx, ex, lb, rb;
  logic        nz, c_trim_r, c_trim_l, c_split, c_del, full, q_hit, d_last;

  assign sx = {2'b00, rd.x};
  assign ex = sx + {2'b00, rd.len} - 15'd1;
  assign lb = {2'b00, span.lb};
  assign rb = {2'b00, span.rb};
  assign nz = (rd.len != 13'd0);
  assign c_trim_r = (lb > sx) && (lb <= ex) && (rb > ex);
  assign c_trim_l = !c_trim_r && (rb >= sx) && (rb <= ex) && (lb <= sx);
  assign c_split  = !c_trim_r && !c_trim_l && (lb > sx) && (rb <= ex);
  assign c_del    = (lb <= sx) && (rb > ex);
  assign full     = (count >= MaxCnt);
  assign q_hit    = nz && !item.x_pos[13] &&
                    ({2'b00, item.x_pos[12:0]} >= sx) &&
                    ({2'b00, item.x_pos[12:0]} < sx + {2'b00, rd.len});
  assign d_last   = (idx + CW'(1) == count);

  // start row clipping, first step
  logic [14:0] negx;
  logic        st_e1;
  assign negx  = 15'(-$signed({item.x_pos[13], item.x_pos}));
  assign st_e1 = item.y_pos[13] || (item.span_w == 13'd0) ||
                 (item.x_pos[13] && (negx >= {2'b00, item.span_w}));

  // clip the start span to the window in S_ST2
  logic        st_final_empty;
  logic [13:0] st_end;
  logic [12:0] st_len;
  assign st_end         = {1'b0, st_x} + {1'b0, st_w};
  assign st_final_empty = st_empty || (st_x >= ww);
  assign st_len         = (st_end > {1'b0, ww}) ? ww - st_x : st_w;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lors_pkg::S_IDLE: begin
        if (accept) begin
          case (lors_pkg::req_t'(s_tuser))
            lors_pkg::REQ_START:   state_next = lors_pkg::S_ST1;
            lors_pkg::REQ_OCCLUDE: state_next = lors_pkg::S_G1;
            lors_pkg::REQ_QUERY:   state_next = lors_pkg::S_QRD;
            default:               state_next = lors_pkg::S_DRD;
          endcase
        end
      end
      lors_pkg::S_ST1: state_next = lors_pkg::S_ST2;
      lors_pkg::S_ST2: state_next = lors_pkg::S_IDLE;
      lors_pkg::S_G1:  state_next = lors_pkg::S_G2;
      lors_pkg::S_G2:  state_next = lors_pkg::S_ORD;
      lors_pkg::S_ORD: begin
        if (!span.hit || idx >= count) state_next = lors_pkg::S_IDLE;
        else state_next = lors_pkg::S_OEV;
      end
      lors_pkg::S_OEV: begin
        if (nz && c_split && !full) state_next = lors_pkg::S_SRD;
        else state_next = lors_pkg::S_ORD;
      end
      lors_pkg::S_SRD: begin
        if (sidx > idx + CW'(1)) state_next = lors_pkg::S_SWR;
        else state_next = lors_pkg::S_W1;
      end
      lors_pkg::S_SWR: state_next = lors_pkg::S_SRD;
      lors_pkg::S_W1:  state_next = lors_pkg::S_W0;
      lors_pkg::S_W0:  state_next = lors_pkg::S_ORD;
      lors_pkg::S_QRD: begin
        if (item.x_pos[13] || idx >= count) state_next = lors_pkg::S_EMIT;
        else state_next = lors_pkg::S_QEV;
      end
      lors_pkg::S_QEV: begin
        if (q_hit) state_next = lors_pkg::S_EMIT;
        else state_next = lors_pkg::S_QRD;
      end
      lors_pkg::S_DRD: begin
        if (count == '0) state_next = lors_pkg::S_EMIT;
        else state_next = lors_pkg::S_DEV;
      end
      lors_pkg::S_DEV: begin
        if (slot_free) state_next = d_last ? lors_pkg::S_IDLE : lors_pkg::S_DRD;
      end
      lors_pkg::S_EMIT: begin
        if (slot_free) state_next = lors_pkg::S_IDLE;
      end
      default: state_next = lors_pkg::S_IDLE;
    endcase
  end

  // control outputs
  logic        out_load, out_valid, out_vis, out_last;
  logic [11:0] out_x;
  logic [12:0] out_len;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = rd;
    ram_re    = 1'b0;
    ram_raddr = idx[AW-1:0];
    out_load  = 1'b0;
    out_x     = '0;
    out_len   = '0;
    out_valid = 1'b0;
    out_vis   = 1'b0;
    out_last  = 1'b1;
    case (state)
      lors_pkg::S_ST2: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{len: st_len, x: st_x};
      end
      lors_pkg::S_ORD, lors_pkg::S_QRD, lors_pkg::S_DRD: ram_re = 1'b1;
      lors_pkg::S_OEV: begin
        ram_we = nz && (c_trim_r || c_trim_l || c_del);
        if (c_trim_r)      ram_wdata = '{len: 13'(lb - sx), x: rd.x};
        else if (c_trim_l) ram_wdata = '{len: 13'(ex - rb), x: 13'(rb + 15'd1)};
        else               ram_wdata = '{len: 13'd0, x: rd.x};
      end
      lors_pkg::S_SRD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(sidx - CW'(1));
      end
      lors_pkg::S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = sidx[AW-1:0];
        ram_wdata = rd;
      end
      lors_pkg::S_W1: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx + CW'(1));
        ram_wdata = '{len: 13'(sp_ex - rb), x: 13'(rb + 15'd1)};
      end
      lors_pkg::S_W0: begin
        ram_we    = 1'b1;
        ram_wdata = '{len: 13'(lb - {2'b00, sp_x}), x: sp_x};
      end
      lors_pkg::S_DEV: begin
        out_load  = slot_free;
        out_x     = rd.x[11:0];
        out_len   = rd.len;
        out_valid = 1'b1;
        out_last  = d_last;
      end
      lors_pkg::S_EMIT: begin
        out_load = slot_free;
        out_vis  = vis;
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lors_pkg::S_IDLE;
      count    <= '0;
      row      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lors_pkg::S_ST1) begin
        count <= '0;
        ovf   <= 1'b0;
        row   <= item.y_pos[12:0];
      end
      if (state == lors_pkg::S_ST2 && !st_final_empty) count <= CW'(1);
      if (state == lors_pkg::S_OEV && nz && c_split && full) ovf <= 1'b1;
      if (state == lors_pkg::S_W0) count <= count + CW'(1);
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= lors_pkg::item_t'(s_tdata[$bits(lors_pkg::item_t)-1:0]);
      idx  <= '0;
      vis  <= 1'b0;
    end
    case (state)
      lors_pkg::S_ST1: begin
        st_empty <= st_e1 ||
                    ({1'b0, item.y_pos[12:0]} >= {1'b0, window_height});
        st_x     <= item.x_pos[13] ? 13'd0 : item.x_pos[12:0];
        st_w     <= item.x_pos[13] ? 13'(item.span_w + item.x_pos[12:0])
                                   : item.span_w;
      end
      lors_pkg::S_ST2: ;
      lors_pkg::S_OEV: begin
        if (nz && c_split && !full) begin
          sidx  <= count;
          sp_x  <= rd.x;
          sp_ex <= ex;
        end else begin
          idx <= idx + CW'(1);
        end
      end
      lors_pkg::S_SWR: sidx <= sidx - CW'(1);
      lors_pkg::S_W0:  idx  <= idx + CW'(2);
      lors_pkg::S_QEV: begin
        if (q_hit) vis <= 1'b1;
        else idx <= idx + CW'(1);
      end
      lors_pkg::S_DEV: if (slot_free) idx <= idx + CW'(1);
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {5'd0, ovf, out_vis, out_len, out_x};
      m_tuser <= out_valid;
      m_tlast <= out_last;
    end
  end

endmodule

FILE: rtl/core/lors_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lors_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/lors_span.sv
// Two-stage pipeline that works out an occluding pane's covered columns.
`timescale 1ns / 1ps

module lors_span (
  input  logic                 clk,
  input  lors_pkg::item_t      item,
  input  logic [12:0]          row,
  input  logic [12:0]          ww,
  input  logic                 sb_left,
  output lors_pkg::span_t      span
);

  // stage 1: raw edges
  logic signed [15:0] xoff, yoff, pw, ph, sbw;
  logic               nob, left;
  logic signed [15:0] tb_c, bb_c, lb_c, rb_c;
  logic signed [15:0] tb, bb, lb_raw, rb_raw;
  logic               nob_q, shown_q, flt_q;

  assign xoff = 16'(item.x_pos);
  assign yoff = 16'(item.y_pos);
  assign pw   = signed'({3'b000, item.span_w});
  assign ph   = signed'({3'b000, item.pane_h});
  assign sbw  = item.scrollbar_reserved ? signed'({8'd0, item.scrollbar_width}) : 16'sd0;
  assign nob  = item.pane_floating & item.pane_borderless;
  assign left = item.scrollbar_reserved & sb_left;

  always_comb begin
    if (nob) begin
      tb_c = yoff;
      bb_c = yoff + ph - 16'sd1;
      lb_c = xoff;
      rb_c = xoff + pw - 16'sd1;
    end else begin
      tb_c = (yoff > 16'sd0) ? yoff - 16'sd1 : 16'sd0;
      bb_c = yoff + ph;
      if (left) begin
        lb_c = (xoff > sbw) ? xoff - 16'sd1 - sbw : 16'sd0;
        rb_c = xoff + pw;
      end else begin
        lb_c = (xoff > 16'sd0) ? xoff - 16'sd1 : 16'sd0;
        rb_c = xoff + pw + sbw;
      end
    end
  end

  always_ff @(posedge clk) begin
    tb      <= tb_c;
    bb      <= bb_c;
    lb_raw  <= lb_c;
    rb_raw  <= rb_c;
    nob_q   <= nob;
    shown_q <= item.pane_visible;
    flt_q   <= item.pane_floating;
  end

  // stage 2: row test and clipping
  logic signed [15:0] py, wws, lb_cl, rb_cl;
  logic               row_miss;

  assign py  = signed'({3'b000, row});
  assign wws = signed'({3'b000, ww});

  always_comb begin
    row_miss = !shown_q || (py < tb) || (py > bb) ||
               (!flt_q && ((py == tb) || (py == bb)));
    lb_cl = (lb_raw < 16'sd0) ? 16'sd0 : lb_raw;
    if ((nob_q && rb_raw >= wws) || (!nob_q && rb_raw > wws)) begin
      rb_cl = wws - 16'sd1;
    end else begin
      rb_cl = rb_raw;
    end
  end

  always_ff @(posedge clk) begin
    span.hit <= !row_miss && (rb_raw >= 16'sd0) && (lb_cl <= rb_cl);
    span.lb  <= lb_cl[12:0];
    span.rb  <= rb_cl[12:0];
  end

endmodule

FILE: rtl/core/lors_checker.sv
// Port-level checks on the range splitter, bound to the top level.
`timescale 1ns / 1ps

module lors_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // every request keeps the block busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // a result without a stored range carries no range and ends its item
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[24:0] == 25'd0 && m_tlast)
    else $error("empty result carries range data");

  // a visible answer only comes from a query
  a_query_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> !m_tuser && m_tlast)
    else $error("visible flag on a dump result");

endmodule

bind line_occlusion_range_splitter lors_checker u_lors_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
